// ===== rtl/core/eff_pkg.sv =====
// Shared types and constants for the Euler face flux block.
`default_nettype none
package eff_pkg;

  localparam int W             = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int G_W           = 18;
  localparam logic [G_W-1:0] G_RESET = 18'd26214;
  localparam int KE_W          = 44;
  localparam int DIFF_W        = 46;
  localparam int PROD_W        = 65;
  localparam int MQ_W          = 63;
  localparam int QUEUE_DEPTH   = 4;
  localparam int QPTR_W        = 2;
  localparam int PADDR_W       = 3;
  localparam int PDATA_W       = 32;
  localparam int REG_IDX_W     = 1;
  localparam logic [REG_IDX_W-1:0] REG_GAMMA = 1'd0;

  typedef enum logic [1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_Z,
    AXIS_RSVD
  } axis_t;

  typedef struct packed {
    logic signed [W-1:0] rho;
    logic signed [W-1:0] mom_x;
    logic signed [W-1:0] mom_y;
    logic signed [W-1:0] mom_z;
    logic signed [W-1:0] en;
    axis_t               axis;
    logic                bad;
  } face_t;

  typedef struct packed {
    logic signed [W-1:0] flux_mass;
    logic signed [W-1:0] flux_mom_x;
    logic signed [W-1:0] flux_mom_y;
    logic signed [W-1:0] flux_mom_z;
    logic signed [W-1:0] flux_energy;
    logic                bad_density;
    logic                saturated;
  } res_t;

endpackage
`default_nettype wire

// ===== rtl/core/eff_in_if.sv =====
// Input channel carrying the two cell states and the flux axis.
`default_nettype none
interface eff_in_if;
  logic                         valid;
  logic                         ready;
  logic signed [eff_pkg::W-1:0] near_density;
  logic signed [eff_pkg::W-1:0] near_mom_x;
  logic signed [eff_pkg::W-1:0] near_mom_y;
  logic signed [eff_pkg::W-1:0] near_mom_z;
  logic signed [eff_pkg::W-1:0] near_energy;
  logic signed [eff_pkg::W-1:0] far_density;
  logic signed [eff_pkg::W-1:0] far_mom_x;
  logic signed [eff_pkg::W-1:0] far_mom_y;
  logic signed [eff_pkg::W-1:0] far_mom_z;
  logic signed [eff_pkg::W-1:0] far_energy;
  logic [1:0]                   action;

  modport source (
    output valid, near_density, near_mom_x, near_mom_y, near_mom_z, near_energy,
    output far_density, far_mom_x, far_mom_y, far_mom_z, far_energy, action,
    input  ready
  );
  modport sink (
    input  valid, near_density, near_mom_x, near_mom_y, near_mom_z, near_energy,
    input  far_density, far_mom_x, far_mom_y, far_mom_z, far_energy, action,
    output ready
  );
endinterface
`default_nettype wire

// ===== rtl/core/eff_out_if.sv =====
// Result channel carrying the five fluxes and the status flags.
`default_nettype none
interface eff_out_if;
  logic                         valid;
  logic                         ready;
  logic signed [eff_pkg::W-1:0] flux_mass;
  logic signed [eff_pkg::W-1:0] flux_mom_x;
  logic signed [eff_pkg::W-1:0] flux_mom_y;
  logic signed [eff_pkg::W-1:0] flux_mom_z;
  logic signed [eff_pkg::W-1:0] flux_energy;
  logic                         bad_density;
  logic                         saturated;

  modport source (
    output valid, flux_mass, flux_mom_x, flux_mom_y, flux_mom_z, flux_energy,
    output bad_density, saturated,
    input  ready
  );
  modport sink (
    input  valid, flux_mass, flux_mom_x, flux_mom_y, flux_mom_z, flux_energy,
    input  bad_density, saturated,
    output ready
  );
endinterface
`default_nettype wire

// ===== rtl/core/eff_front.sv =====
// Front end: accept a face transaction, average the two states, classify axis and density.
`default_nettype none
module eff_front (
  eff_in_if.sink          in_ch,
  input  logic            full,
  output logic            push,
  output eff_pkg::face_t  face
);

  localparam int W = eff_pkg::W;

  function automatic logic signed [W-1:0] avg(input logic signed [W-1:0] a,
                                              input logic signed [W-1:0] b);
    logic [W:0] s;
    s = {a[W-1], a} + {b[W-1], b};
    return s[W:1];
  endfunction

  eff_pkg::axis_t axis_raw;

  assign in_ch.ready = !full;
  assign push        = in_ch.valid && !full;
  assign axis_raw    = eff_pkg::axis_t'(in_ch.action);

  always_comb begin
    face.rho   = avg(in_ch.near_density, in_ch.far_density);
    face.mom_x = avg(in_ch.near_mom_x, in_ch.far_mom_x);
    face.mom_y = avg(in_ch.near_mom_y, in_ch.far_mom_y);
    face.mom_z = avg(in_ch.near_mom_z, in_ch.far_mom_z);
    face.en    = avg(in_ch.near_energy, in_ch.far_energy);
    face.axis  = (axis_raw == eff_pkg::AXIS_RSVD) ? eff_pkg::AXIS_Z : axis_raw;
    face.bad   = face.rho[W-1] || (face.rho == '0);
  end

endmodule
`default_nettype wire

// ===== rtl/core/eff_queue.sv =====
// Short queue between the front end and the arithmetic back end.
`default_nettype none
module eff_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  eff_pkg::face_t  wdata,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output eff_pkg::face_t  rdata
);

  localparam int DEPTH = eff_pkg::QUEUE_DEPTH;
  localparam int PTR_W = eff_pkg::QPTR_W;

  eff_pkg::face_t   mem [0:DEPTH-1];
  logic [PTR_W-1:0] wp_r;
  logic [PTR_W-1:0] rp_r;
  logic [PTR_W:0]   cnt_r;

  assign full  = (cnt_r == (PTR_W+1)'(DEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = mem[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= rp_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (!push && pop) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/eff_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with quotient overflow flag.
`default_nettype none
module eff_div #(
  parameter int NUM_W = 64,
  parameter int DEN_W = 32,
  parameter int Q_W   = 32
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [Q_W-1:0]   quo,
  output logic             ovf
);

  localparam int TOP_W = NUM_W - Q_W;
  localparam int CMP_W = (TOP_W > DEN_W) ? TOP_W : DEN_W;

  logic [CMP_W-1:0] top_ext;
  logic [CMP_W-1:0] den_ext;
  logic [DEN_W-1:0] rem_r [0:Q_W];
  logic [Q_W-1:0]   low_r [0:Q_W];
  logic [Q_W-1:0]   quo_r [0:Q_W];
  logic [DEN_W-1:0] den_r [0:Q_W];
  logic             ovf_r [0:Q_W];
  logic [DEN_W:0]   trial [1:Q_W];

  assign top_ext = CMP_W'(num[NUM_W-1:Q_W]);
  assign den_ext = CMP_W'(den);

  always_comb begin
    for (int i = 1; i <= Q_W; i++) begin
      trial[i] = {rem_r[i-1], low_r[i-1][Q_W-1]} - {1'b0, den_r[i-1]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= top_ext[DEN_W-1:0];
      low_r[0] <= num[Q_W-1:0];
      quo_r[0] <= '0;
      den_r[0] <= den;
      ovf_r[0] <= (top_ext >= den_ext);
      for (int i = 1; i <= Q_W; i++) begin
        if (trial[i][DEN_W]) begin
          rem_r[i] <= {rem_r[i-1][DEN_W-2:0], low_r[i-1][Q_W-1]};
        end else begin
          rem_r[i] <= trial[i][DEN_W-1:0];
        end
        low_r[i] <= low_r[i-1] << 1;
        quo_r[i] <= {quo_r[i-1][Q_W-2:0], ~trial[i][DEN_W]};
        den_r[i] <= den_r[i-1];
        ovf_r[i] <= ovf_r[i-1];
      end
    end
  end

  assign quo = quo_r[Q_W];
  assign ovf = ovf_r[Q_W];

endmodule
`default_nettype wire

// ===== rtl/core/eff_dly.sv =====
// Enabled delay line that keeps side data aligned with the divider pipelines.
`default_nettype none
module eff_dly #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] d,
  output logic [WIDTH-1:0] q
);

  logic [WIDTH-1:0] sr_r [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (en) begin
      sr_r[0] <= d;
      for (int i = 1; i < DEPTH; i++) begin
        sr_r[i] <= sr_r[i-1];
      end
    end
  end

  assign q = sr_r[DEPTH-1];

endmodule
`default_nettype wire

// ===== rtl/core/eff_back.sv =====
// Back end: kinetic term, pressure, the mass flux and the four momentum and energy flux quotients, with saturation.
`default_nettype none
module eff_back #(
  parameter int FRAC_BITS = eff_pkg::FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [eff_pkg::G_W-1:0]  g,
  input  logic                     empty,
  input  eff_pkg::face_t           head,
  output logic                     pop,
  input  logic                     out_ready,
  output logic                     out_valid,
  output eff_pkg::res_t            res
);

  localparam int W      = eff_pkg::W;
  localparam int KE_W   = eff_pkg::KE_W;
  localparam int DIFF_W = eff_pkg::DIFF_W;
  localparam int PROD_W = eff_pkg::PROD_W;
  localparam int MQ_W   = eff_pkg::MQ_W;
  localparam int P_W    = PROD_W - FRAC_BITS;
  localparam int HSUM_W = P_W + 1;
  localparam int N_W    = W + HSUM_W;
  localparam int SUM_W  = ((MQ_W + 1 > P_W) ? MQ_W + 1 : P_W) + 1;
  localparam int KE_LAT  = KE_W + 1;
  localparam int MOM_LAT = MQ_W + 1;
  localparam int E_LAT   = W + 1;
  localparam int S_KE    = 2 + KE_LAT;
  localparam int S_N     = S_KE + 5;
  localparam int S_END   = S_N + E_LAT;
  localparam int S_MOM   = 1 + MOM_LAT;
  localparam int MOM_DLY = S_END - S_MOM;
  localparam int MQP_W   = MQ_W + 1;

  typedef struct packed {
    logic signed [W-1:0] rho;
    logic signed [W-1:0] en;
    logic signed [W-1:0] mn;
    eff_pkg::axis_t      axis;
    logic                bad;
    logic                satk;
  } carry_t;

  typedef struct packed {
    logic signed [P_W-1:0] p;
    logic signed [W-1:0]   mn;
    eff_pkg::axis_t        axis;
    logic                  bad;
    logic                  satk;
    logic                  esg;
  } tail_t;

  function automatic logic [W-1:0] absv(input logic [W-1:0] v);
    return v[W-1] ? (~v + 1'b1) : v;
  endfunction

  function automatic logic [W:0] clip(input logic [SUM_W-1:0] v);
    logic [SUM_W-W:0] top;
    top = v[SUM_W-1:W-1];
    if ((&top) || !(|top)) begin
      return {1'b0, v[W-1:0]};
    end
    return {1'b1, v[SUM_W-1], {(W-1){~v[SUM_W-1]}}};
  endfunction

  logic               adv;
  logic [S_END:0]     vld_r;
  logic               out_valid_r;
  eff_pkg::res_t      res_r;
  eff_pkg::res_t      res_nxt;

  assign adv       = !out_valid_r || out_ready;
  assign pop       = adv && !empty;
  assign out_valid = out_valid_r;
  assign res       = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= {vld_r[S_END-1:0], pop};
      out_valid_r <= vld_r[S_END];
    end
  end

  // stage 0: queue head
  eff_pkg::face_t      s0_r;
  logic signed [W-1:0] mom0 [0:2];
  logic signed [W-1:0] mn0;
  logic [W-1:0]        am0 [0:2];
  logic [W-1:0]        mnm0;

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_r <= head;
    end
  end

  assign mom0[0] = s0_r.mom_x;
  assign mom0[1] = s0_r.mom_y;
  assign mom0[2] = s0_r.mom_z;

  always_comb begin
    case (s0_r.axis)
      eff_pkg::AXIS_X: mn0 = s0_r.mom_x;
      eff_pkg::AXIS_Y: mn0 = s0_r.mom_y;
      default:         mn0 = s0_r.mom_z;
    endcase
    for (int k = 0; k < 3; k++) begin
      am0[k] = absv(mom0[k]);
    end
    mnm0 = absv(mn0);
  end

  // stage 1: squares and momentum products
  logic [2*W-1:0] sq_r [0:2];
  logic [2*W-1:0] pm_r [0:2];
  logic [2:0]     sg_r;
  carry_t         b1_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        sq_r[k] <= am0[k] * am0[k];
        pm_r[k] <= mnm0 * am0[k];
        sg_r[k] <= mn0[W-1] ^ mom0[k][W-1];
      end
      b1_r.rho  <= s0_r.rho;
      b1_r.en   <= s0_r.en;
      b1_r.mn   <= mn0;
      b1_r.axis <= s0_r.axis;
      b1_r.bad  <= s0_r.bad;
      b1_r.satk <= 1'b0;
    end
  end

  // momentum flux quotients
  logic [MQ_W-1:0]      mq   [0:2];
  logic [2:0]           movf;
  logic [3*MQP_W-1:0]   mq_pack;
  logic [3*MQP_W-1:0]   mq_pack_e;
  logic [MQ_W-1:0]      mq_e [0:2];
  logic [2:0]           movf_e;
  logic [2:0]           sg_e;

  for (genvar k = 0; k < 3; k++) begin : g_mom
    eff_div #(.NUM_W(2*W), .DEN_W(W), .Q_W(MQ_W)) u_div (
      .clk (clk),
      .en  (adv),
      .num (pm_r[k]),
      .den (b1_r.rho),
      .quo (mq[k]),
      .ovf (movf[k])
    );
    assign mq_pack[k*MQP_W +: MQP_W] = {movf[k], mq[k]};
    assign movf_e[k] = mq_pack_e[k*MQP_W + MQ_W];
    assign mq_e[k]   = mq_pack_e[k*MQP_W +: MQ_W];
  end

  eff_dly #(.WIDTH(3*MQP_W), .DEPTH(MOM_DLY)) u_mq_dly (
    .clk (clk),
    .en  (adv),
    .d   (mq_pack),
    .q   (mq_pack_e)
  );

  eff_dly #(.WIDTH(3), .DEPTH(S_END-1)) u_sg_dly (
    .clk (clk),
    .en  (adv),
    .d   (sg_r),
    .q   (sg_e)
  );

  // stage 2: squared momentum magnitude
  logic [2*W-1:0] msq_r;
  carry_t         b2_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      msq_r <= sq_r[0] + sq_r[1] + sq_r[2];
      b2_r  <= b1_r;
    end
  end

  // kinetic term
  logic [KE_W-1:0]           ke_q;
  logic                      ke_ovf;
  logic [$bits(carry_t)-1:0] c_ke_v;
  carry_t                    c_ke;
  carry_t                    c_ke_s;

  eff_div #(.NUM_W(2*W), .DEN_W(W), .Q_W(KE_W)) u_ke_div (
    .clk (clk),
    .en  (adv),
    .num (msq_r),
    .den ({b2_r.rho[W-2:0], 1'b0}),
    .quo (ke_q),
    .ovf (ke_ovf)
  );

  eff_dly #(.WIDTH($bits(carry_t)), .DEPTH(KE_LAT)) u_ke_dly (
    .clk (clk),
    .en  (adv),
    .d   (b2_r),
    .q   (c_ke_v)
  );

  assign c_ke = c_ke_v;

  always_comb begin
    c_ke_s      = c_ke;
    c_ke_s.satk = ke_ovf;
  end

  // pressure
  logic signed [DIFF_W-1:0] diff_r;
  carry_t                   b48_r;
  logic signed [PROD_W-1:0] prod_r;
  carry_t                   b49_r;
  logic [P_W-1:0]           pw;
  logic signed [P_W-1:0]    p_r;
  logic signed [HSUM_W-1:0] hsum_r;
  carry_t                   b50_r;
  logic [KE_W-1:0]          ke_c;

  assign ke_c = ke_ovf ? {KE_W{1'b1}} : ke_q;
  assign pw   = prod_r[PROD_W-1:FRAC_BITS];

  always_ff @(posedge clk) begin
    if (adv) begin
      diff_r     <= $signed({{(DIFF_W-W){c_ke.en[W-1]}}, c_ke.en})
                  - $signed({{(DIFF_W-KE_W){1'b0}}, ke_c});
      b48_r      <= c_ke_s;
      prod_r     <= $signed({1'b0, g}) * diff_r;
      b49_r      <= b48_r;
      p_r        <= pw;
      hsum_r     <= $signed({pw[P_W-1], pw})
                  + $signed({{(HSUM_W-W){b49_r.en[W-1]}}, b49_r.en});
      b50_r      <= b49_r;
    end
  end

  // energy numerator
  logic [HSUM_W-1:0]     hm;
  logic [W-1:0]          mnm50;
  logic [2*W-1:0]        plo_r;
  logic [HSUM_W-1:0]     phi_r;
  logic                  esg_r;
  logic signed [P_W-1:0] p51_r;
  carry_t                b51_r;
  logic [N_W-1:0]        n_r;
  tail_t                 t52_r;
  logic [W-1:0]          rho52_r;

  assign hm    = hsum_r[HSUM_W-1] ? (~hsum_r + 1'b1) : hsum_r;
  assign mnm50 = absv(b50_r.mn);

  always_ff @(posedge clk) begin
    if (adv) begin
      plo_r      <= mnm50 * hm[W-1:0];
      phi_r      <= mnm50 * hm[HSUM_W-1:W];
      esg_r      <= b50_r.mn[W-1] ^ hsum_r[HSUM_W-1];
      p51_r      <= p_r;
      b51_r      <= b50_r;
      n_r        <= {phi_r, {W{1'b0}}} + N_W'(plo_r);
      t52_r.p    <= p51_r;
      t52_r.mn   <= b51_r.mn;
      t52_r.axis <= b51_r.axis;
      t52_r.bad  <= b51_r.bad;
      t52_r.satk <= b51_r.satk;
      t52_r.esg  <= esg_r;
      rho52_r    <= b51_r.rho;
    end
  end

  logic [W-1:0]             eq;
  logic                     eovf;
  logic [$bits(tail_t)-1:0] t_e_v;
  tail_t                    t_e;

  eff_div #(.NUM_W(N_W), .DEN_W(W), .Q_W(W)) u_e_div (
    .clk (clk),
    .en  (adv),
    .num (n_r),
    .den (rho52_r),
    .quo (eq),
    .ovf (eovf)
  );

  eff_dly #(.WIDTH($bits(tail_t)), .DEPTH(E_LAT)) u_tail_dly (
    .clk (clk),
    .en  (adv),
    .d   (t52_r),
    .q   (t_e_v)
  );

  assign t_e = t_e_v;

  // final sums and clipping
  logic [2:0]       on_ax;
  logic [SUM_W-1:0] v;
  logic [W:0]       cl;
  logic [W-1:0]     fm [0:2];
  logic [2:0]       fsat;
  logic [W-1:0]     fe;
  logic             esat;
  logic [SUM_W-1:0] pext;

  assign on_ax[0] = (t_e.axis == eff_pkg::AXIS_X);
  assign on_ax[1] = (t_e.axis == eff_pkg::AXIS_Y);
  assign on_ax[2] = !on_ax[0] && !on_ax[1];
  assign pext     = {{(SUM_W-P_W){t_e.p[P_W-1]}}, t_e.p};

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      v = sg_e[k] ? -SUM_W'(mq_e[k]) : SUM_W'(mq_e[k]);
      if (on_ax[k]) begin
        v = v + pext;
      end
      cl = clip(v);
      if (movf_e[k]) begin
        fsat[k] = 1'b1;
        fm[k]   = {sg_e[k], {(W-1){~sg_e[k]}}};
      end else begin
        fsat[k] = cl[W];
        fm[k]   = cl[W-1:0];
      end
    end
    v  = t_e.esg ? -SUM_W'(eq) : SUM_W'(eq);
    cl = clip(v);
    if (eovf) begin
      esat = 1'b1;
      fe   = {t_e.esg, {(W-1){~t_e.esg}}};
    end else begin
      esat = cl[W];
      fe   = cl[W-1:0];
    end
    if (t_e.bad) begin
      res_nxt = '0;
      res_nxt.bad_density = 1'b1;
    end else begin
      res_nxt.flux_mass   = t_e.mn;
      res_nxt.flux_mom_x  = fm[0];
      res_nxt.flux_mom_y  = fm[1];
      res_nxt.flux_mom_z  = fm[2];
      res_nxt.flux_energy = fe;
      res_nxt.bad_density = 1'b0;
      res_nxt.saturated   = t_e.satk || (|fsat) || esat;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/euler_face_flux.sv =====
// Top level of the Euler face flux block: channels, register port and the front/back split.
//
// Each face transaction carries the conserved states of two neighboring cells and an axis;
// the block averages them, forms the pressure from the gamma_minus_one register and returns
// the five Euler fluxes in signed fixed point, with flags for non-positive density and for
// saturation. One face is taken per clock cycle, sustained, while the result side does not
// stall. The pipeline depth is set by the pipelined restoring dividers, one quotient bit per
// stage: the 45-stage kinetic-term divider followed by the 33-stage energy-flux divider, plus
// the surrounding multiply stages. A four-entry queue decouples input acceptance from the
// arithmetic pipeline, which stalls as a whole only while a finished result is held waiting
// on the output. Write gamma_minus_one only while no transaction is in flight.
`default_nettype none
module euler_face_flux #(
  parameter int FRAC_BITS = eff_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  eff_in_if.sink                        in_ch,
  eff_out_if.source                     out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [eff_pkg::PADDR_W-1:0]   paddr,
  input  logic [eff_pkg::PDATA_W-1:0]   pwdata,
  output logic [eff_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  localparam int G_W     = eff_pkg::G_W;
  localparam int PDATA_W = eff_pkg::PDATA_W;
  localparam int PADDR_W = eff_pkg::PADDR_W;

  logic [G_W-1:0]                   gamma_r;
  logic [eff_pkg::REG_IDX_W-1:0]    reg_idx;
  logic                             full;
  logic                             empty;
  logic                             push;
  logic                             pop;
  eff_pkg::face_t                   face_in;
  eff_pkg::face_t                   face_head;
  eff_pkg::res_t                    res;

  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign prdata  = (reg_idx == eff_pkg::REG_GAMMA) ? {{(PDATA_W-G_W){1'b0}}, gamma_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gamma_r <= eff_pkg::G_RESET;
    end else if (psel && penable && pwrite && pready && (reg_idx == eff_pkg::REG_GAMMA)) begin
      gamma_r <= pwdata[G_W-1:0];
    end
  end

  eff_front u_front (
    .in_ch (in_ch),
    .full  (full),
    .push  (push),
    .face  (face_in)
  );

  eff_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (face_in),
    .full  (full),
    .pop   (pop),
    .empty (empty),
    .rdata (face_head)
  );

  eff_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .g         (gamma_r),
    .empty     (empty),
    .head      (face_head),
    .pop       (pop),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .res       (res)
  );

  assign out_ch.flux_mass   = res.flux_mass;
  assign out_ch.flux_mom_x  = res.flux_mom_x;
  assign out_ch.flux_mom_y  = res.flux_mom_y;
  assign out_ch.flux_mom_z  = res.flux_mom_z;
  assign out_ch.flux_energy = res.flux_energy;
  assign out_ch.bad_density = res.bad_density;
  assign out_ch.saturated   = res.saturated;

endmodule
`default_nettype wire

// ===== tb/euler_face_flux_checker.sv =====
// Checker for the Euler face flux block: predicts each face's fluxes and compares results.
`timescale 1ns / 1ps
module euler_face_flux_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  eff_in_if                           in_mon,
  eff_out_if                          out_mon,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [eff_pkg::PADDR_W-1:0] paddr,
  input  logic [eff_pkg::PDATA_W-1:0] pwdata,
  input  logic                        pready,
  output int                          errors,
  output int                          pending
);

  localparam int W       = eff_pkg::W;
  localparam int G_W     = eff_pkg::G_W;
  localparam int PADDR_W = eff_pkg::PADDR_W;
  localparam logic signed [127:0] QUO_LIM = 128'sd1 <<< 62;
  localparam logic signed [127:0] KE_LIM  = (128'sd1 <<< 44) - 1;
  localparam logic signed [127:0] S32_MAX = 128'sd2147483647;
  localparam logic signed [127:0] S32_MIN = -128'sd2147483648;

  logic [G_W-1:0]  gamma_m1;
  eff_pkg::res_t   flux_queue[$];

  function automatic logic signed [127:0] prod_over_rho(input logic signed [127:0] a,
                                                        input logic signed [127:0] b,
                                                        input logic signed [127:0] d);
    logic [127:0] ua, ub, q;
    logic         neg;
    neg = (a < 0) != (b < 0);
    ua  = (a < 0) ? -a : a;
    ub  = (b < 0) ? -b : b;
    q   = (ua * ub) / d;
    if (q > QUO_LIM) q = QUO_LIM;
    return neg ? -$signed(q) : $signed(q);
  endfunction

  function automatic logic signed [W-1:0] clip32(input logic signed [127:0] v,
                                                 inout logic sat);
    if (v > S32_MAX) begin
      sat = 1'b1;
      return S32_MAX[W-1:0];
    end
    if (v < S32_MIN) begin
      sat = 1'b1;
      return S32_MIN[W-1:0];
    end
    return v[W-1:0];
  endfunction

  function automatic eff_pkg::res_t face_flux();
    eff_pkg::res_t       r;
    logic signed [127:0] rho, en, ke, p, mn, msq, q;
    logic signed [127:0] mom[3];
    logic signed [W-1:0] fl[3];
    eff_pkg::axis_t      ax;
    logic                sat;
    r   = '0;
    sat = 1'b0;
    ax  = eff_pkg::axis_t'(in_mon.action);
    if (ax == eff_pkg::AXIS_RSVD) ax = eff_pkg::AXIS_Z;
    rho    = (128'(in_mon.near_density) + 128'(in_mon.far_density)) >>> 1;
    mom[0] = (128'(in_mon.near_mom_x) + 128'(in_mon.far_mom_x)) >>> 1;
    mom[1] = (128'(in_mon.near_mom_y) + 128'(in_mon.far_mom_y)) >>> 1;
    mom[2] = (128'(in_mon.near_mom_z) + 128'(in_mon.far_mom_z)) >>> 1;
    en     = (128'(in_mon.near_energy) + 128'(in_mon.far_energy)) >>> 1;
    if (rho <= 0) begin
      r.bad_density = 1'b1;
      return r;
    end
    msq = mom[0] * mom[0] + mom[1] * mom[1] + mom[2] * mom[2];
    ke  = msq / (2 * rho);
    if (ke > KE_LIM) begin
      ke  = KE_LIM;
      sat = 1'b1;
    end
    p  = ($signed({110'd0, gamma_m1}) * (en - ke)) >>> eff_pkg::FRAC_BITS_DEF;
    mn = mom[ax];
    for (int k = 0; k < 3; k++) begin
      q = prod_over_rho(mn, mom[k], rho);
      if (k == int'(ax)) q = q + p;
      fl[k] = clip32(q, sat);
    end
    r.flux_mass   = mn[W-1:0];
    r.flux_mom_x  = fl[0];
    r.flux_mom_y  = fl[1];
    r.flux_mom_z  = fl[2];
    r.flux_energy = clip32(prod_over_rho(mn, en + p, rho), sat);
    r.saturated   = sat;
    return r;
  endfunction

  always @(posedge clk) begin
    eff_pkg::res_t want, got;
    logic [W-1:0]  wv[7], gv[7];
    string         nm[7];
    int            nbad;
    if (!rst_n) begin
      gamma_m1 <= eff_pkg::G_RESET;
      errors   <= 0;
      pending  <= 0;
      flux_queue.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr[PADDR_W-1:2] == eff_pkg::REG_GAMMA)
        gamma_m1 <= pwdata[G_W-1:0];
      if (in_mon.valid && in_mon.ready)
        flux_queue.push_back(face_flux());
      if (out_mon.valid && out_mon.ready) begin
        got.flux_mass   = out_mon.flux_mass;
        got.flux_mom_x  = out_mon.flux_mom_x;
        got.flux_mom_y  = out_mon.flux_mom_y;
        got.flux_mom_z  = out_mon.flux_mom_z;
        got.flux_energy = out_mon.flux_energy;
        got.bad_density = out_mon.bad_density;
        got.saturated   = out_mon.saturated;
        if (flux_queue.size() == 0) begin
          $display("%0t: unexpected result transaction %h", $time, got);
          errors <= errors + 1;
        end else begin
          want = flux_queue.pop_front();
          nm = '{"flux_mass", "flux_mom_x", "flux_mom_y", "flux_mom_z", "flux_energy",
                 "bad_density", "saturated"};
          wv = '{want.flux_mass, want.flux_mom_x, want.flux_mom_y, want.flux_mom_z,
                 want.flux_energy, 32'(want.bad_density), 32'(want.saturated)};
          gv = '{got.flux_mass, got.flux_mom_x, got.flux_mom_y, got.flux_mom_z,
                 got.flux_energy, 32'(got.bad_density), 32'(got.saturated)};
          nbad = 0;
          for (int i = 0; i < 7; i++)
            if (wv[i] !== gv[i]) begin
              $display("%0t: %s expected %h actual %h", $time, nm[i], wv[i], gv[i]);
              nbad++;
            end
          errors <= errors + nbad;
        end
      end
      pending <= flux_queue.size();
    end
  end
endmodule

// ===== tb/euler_face_flux_tb.sv =====
// Top of the Euler face flux testbench: clock, reset, face stimulus, register writes, verdict.
`timescale 1ns / 1ps
module euler_face_flux_tb;

  localparam int W       = eff_pkg::W;
  localparam int PADDR_W = eff_pkg::PADDR_W;
  localparam int PDATA_W = eff_pkg::PDATA_W;
  localparam int LIMIT   = 400000;

  typedef struct {
    logic signed [W-1:0] v[10];
    logic [1:0]          act;
  } cell_pair_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [PADDR_W-1:0]   paddr = '0;
  logic [PDATA_W-1:0]   pwdata = '0;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;
  int                   errors, pending, cycles = 0;

  eff_in_if  in_ch ();
  eff_out_if out_ch ();

  euler_face_flux DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  euler_face_flux_checker chk (
    .clk(clk), .rst_n(rst_n), .in_mon(in_ch), .out_mon(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready), .errors(errors), .pending(pending)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // result side: free-running, random, and long-stall stretches
  int stall_left = 0;
  initial out_ch.ready = 1'b0;
  always @(posedge clk) begin
    int mode;
    mode = (cycles / 600) % 3;
    if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (mode == 0) begin
      out_ch.ready <= 1'b1;
    end else if (mode == 1) begin
      out_ch.ready <= ($urandom_range(0, 9) > 2);
    end else begin
      out_ch.ready <= 1'b1;
      if ($urandom_range(0, 19) == 0) stall_left <= $urandom_range(1, 15);
    end
  end

  task automatic reg_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic send_face(input cell_pair_t c);
    in_ch.valid        <= 1'b1;
    in_ch.near_density <= c.v[0];
    in_ch.near_mom_x   <= c.v[1];
    in_ch.near_mom_y   <= c.v[2];
    in_ch.near_mom_z   <= c.v[3];
    in_ch.near_energy  <= c.v[4];
    in_ch.far_density  <= c.v[5];
    in_ch.far_mom_x    <= c.v[6];
    in_ch.far_mom_y    <= c.v[7];
    in_ch.far_mom_z    <= c.v[8];
    in_ch.far_energy   <= c.v[9];
    in_ch.action       <= c.act;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  function automatic logic signed [W-1:0] corner_value();
    case ($urandom_range(0, 6))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 0;
      3: return 1;
      4: return -1;
      5: return $signed($urandom_range(0, 65535)) <<< $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  function automatic cell_pair_t random_face();
    cell_pair_t c;
    int         kind;
    kind  = $urandom_range(0, 99);
    c.act = $urandom_range(0, 3);
    for (int i = 0; i < 10; i++) begin
      if (kind < 60) begin
        if (i % 5 == 0) c.v[i] = $urandom_range(1, 1 << 22);
        else if (i % 5 == 4) c.v[i] = $urandom_range(0, 1 << 26);
        else c.v[i] = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
      end else if (kind < 70) begin
        c.v[i] = (i % 5 == 0) ? -$signed($urandom_range(0, 1 << 24))
                              : $signed($urandom_range(0, 1 << 22)) - (1 << 21);
      end else if (kind < 85) begin
        c.v[i] = $urandom;
      end else begin
        c.v[i] = corner_value();
      end
    end
    return c;
  endfunction

  task automatic run_random(input int count);
    int left;
    left = 0;
    for (int n = 0; n < count; n++) begin
      if (left == 0) begin
        left = $urandom_range(1, 40);
        if ($urandom_range(0, 3) != 0) begin
          in_ch.valid <= 1'b0;
          repeat ($urandom_range(1, 8)) @(posedge clk);
        end
      end
      send_face(random_face());
      left--;
    end
  endtask

  function automatic cell_pair_t uniform_face(input logic signed [W-1:0] rho,
                                              input logic signed [W-1:0] mx,
                                              input logic signed [W-1:0] my,
                                              input logic signed [W-1:0] mz,
                                              input logic signed [W-1:0] en,
                                              input eff_pkg::axis_t ax);
    cell_pair_t c;
    c.v = '{rho, mx, my, mz, en, rho, mx, my, mz, en};
    c.act = ax;
    return c;
  endfunction

  initial begin
    cell_pair_t c;
    in_ch.valid        = 1'b0;
    in_ch.near_density = '0;
    in_ch.near_mom_x   = '0;
    in_ch.near_mom_y   = '0;
    in_ch.near_mom_z   = '0;
    in_ch.near_energy  = '0;
    in_ch.far_density  = '0;
    in_ch.far_mom_x    = '0;
    in_ch.far_mom_y    = '0;
    in_ch.far_mom_z    = '0;
    in_ch.far_energy   = '0;
    in_ch.action       = eff_pkg::AXIS_X;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed faces at the reset gamma
    send_face(uniform_face(32'sh10000, 32'sh8000, -32'sh4000, 32'sh2000, 32'sh30000,
                           eff_pkg::AXIS_X));
    send_face(uniform_face(32'sh10000, 32'sh8000, -32'sh4000, 32'sh2000, 32'sh30000,
                           eff_pkg::AXIS_Y));
    send_face(uniform_face(32'sh10000, 32'sh8000, -32'sh4000, 32'sh2000, 32'sh30000,
                           eff_pkg::AXIS_Z));
    send_face(uniform_face(32'sh10000, 32'sh8000, -32'sh4000, 32'sh2000, 32'sh30000,
                           eff_pkg::AXIS_RSVD));
    send_face(uniform_face(0, 32'sh1000, 0, 0, 32'sh1000, eff_pkg::AXIS_X));
    send_face(uniform_face(-32'sh10000, 32'sh1000, 0, 0, 32'sh1000, eff_pkg::AXIS_Y));
    send_face(uniform_face(32'sh80000000, 32'sh7fffffff, 0, 0, 0, eff_pkg::AXIS_Z));
    send_face(uniform_face(1, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 0,
                           eff_pkg::AXIS_X));
    send_face(uniform_face(1, 32'sh80000000, 32'sh80000000, 32'sh80000000,
                           32'sh80000000, eff_pkg::AXIS_Y));
    send_face(uniform_face(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                           32'sh7fffffff, eff_pkg::AXIS_Z));
    send_face(uniform_face(1, 1, -1, 0, 32'sh7fffffff, eff_pkg::AXIS_X));
    send_face(uniform_face(32'sh100, 32'sh1000000, 0, 0, -32'sh7fffffff, eff_pkg::AXIS_X));
    send_face(uniform_face(32'sh10000, 0, 0, 0, -32'sh10000, eff_pkg::AXIS_Y));
    c = uniform_face(1, 0, 0, 0, 0, eff_pkg::AXIS_X);
    c.v[5] = 32'sh80000000;
    send_face(c);
    c = uniform_face(32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 1, -1, eff_pkg::AXIS_Z);
    c.v[0] = 32'sh7fffffff;
    c.v[5] = 32'sh80000000 + 3;
    send_face(c);
    c = uniform_face(3, 32'sh40000, 32'sh40000, 32'sh40000, 32'sh40000, eff_pkg::AXIS_Y);
    c.v[5] = 0;
    send_face(c);
    run_random(500);
    drain();

    reg_write(4, 32'h3ffff);
    reg_write(0, 0);
    send_face(uniform_face(32'sh10000, 32'sh8000, 32'sh4000, 32'sh2000, 32'sh30000,
                           eff_pkg::AXIS_X));
    run_random(300);
    drain();

    reg_write(0, 131072);
    send_face(uniform_face(1, 32'sh7fffffff, 0, 0, 32'sh7fffffff, eff_pkg::AXIS_X));
    send_face(uniform_face(32'sh10000, 32'sh8000, 32'sh4000, 32'sh2000,
                           -32'sh7fffffff, eff_pkg::AXIS_X));
    run_random(500);
    drain();

    reg_write(0, $urandom_range(0, 131072));
    run_random(500);
    drain();

    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule
